>>> src/swarq_pkg.sv
// Shared types and constants for the sliding-window ARQ sender.
package swarq_pkg;

    localparam int SEQ_W         = 32;
    localparam int CFG_W         = 6;
    localparam int OUT_SLOT_W    = 6;
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = SEQ_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd8;

    typedef enum logic [0:0] {
        CFG_WINDOW = 1'b0,
        CFG_MODE   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_NEW    = 3'd0,
        STAT_RESEND = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_ACK    = 3'd3,
        STAT_NONE   = 3'd4,
        STAT_ERROR  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_EXEC,
        S_SLIDE,
        S_SCAN
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [SEQ_W-1:0]   ack_seq;
        logic               ack_good;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [SEQ_W-1:0]       packet_seq;
        logic [OUT_SLOT_W-1:0]  slot_index;
        logic [SEQ_W-1:0]       window_base;
        logic                   last_of_run;
    } out_item_t;

    typedef struct packed {
        logic clear_all;
        logic set_en;
        logic clr_en;
    } amap_ctrl_t;

endpackage

>>> src/sliding_window_arq_sender_core.sv
// Top level of the sliding-window ARQ sender: window state, sequencer and result register.
//
//  channel   | signals                           | handshake
//  ----------+-----------------------------------+-------------------------------
//  item in   | start, busy, item                 | taken when start && !busy
//  result    | result_valid, result              | one-cycle strobe, no back-pressure
//  config    | cfg_wr_en, cfg_index, cfg_data    | written when cfg_wr_en is high
//
//  Send, timeout and selective-repeat good acks run the slot remainder through the shared
//  divider, which works through the sequence number four bits at a time.
//  Go-back-N acks, bad acks and unused actions skip the divider.
//  A base slide clears acknowledged slots in turn; a timeout scans each outstanding
//  sequence, up to the window size, with at most one result a cycle.
//  Reset (rst_n low) clears all window state and acknowledge flags at once.
module sliding_window_arq_sender_core #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  swarq_pkg::in_item_t                 item,
    input  logic                                cfg_wr_en,
    input  swarq_pkg::cfg_reg_t                 cfg_index,
    input  logic [swarq_pkg::CFG_W-1:0]         cfg_data,
    output logic                                result_valid,
    output swarq_pkg::out_item_t                result
);

    localparam int SLOT_W = $clog2(MAX_WINDOW + 1);
    localparam int RING_W = $clog2(MAX_WINDOW + 2);
    localparam int DEPTH  = MAX_WINDOW + 1;
    localparam logic [swarq_pkg::CFG_W-1:0] MAXW_CFG = swarq_pkg::CFG_W'(MAX_WINDOW);

    swarq_pkg::state_t               state_reg;
    swarq_pkg::state_t               state_next;
    swarq_pkg::in_item_t             item_reg;
    swarq_pkg::in_item_t             item_next;
    logic [swarq_pkg::CFG_W-1:0]     win_cfg_reg;
    logic                            repeat_mode_reg;
    logic [swarq_pkg::SEQ_W-1:0]     next_seq_reg;
    logic [swarq_pkg::SEQ_W-1:0]     next_seq_next;
    logic [swarq_pkg::SEQ_W-1:0]     base_seq_reg;
    logic [swarq_pkg::SEQ_W-1:0]     base_seq_next;
    logic [swarq_pkg::SEQ_W-1:0]     seq_reg;
    logic [swarq_pkg::SEQ_W-1:0]     seq_next;
    logic [SLOT_W-1:0]               slot_reg;
    logic [SLOT_W-1:0]               slot_next;
    logic [SLOT_W-1:0]               cnt_reg;
    logic [SLOT_W-1:0]               cnt_next;
    logic [SLOT_W-1:0]               lim_reg;
    logic [SLOT_W-1:0]               lim_next;
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [swarq_pkg::SEQ_W-1:0]     pend_seq_reg;
    logic [swarq_pkg::SEQ_W-1:0]     pend_seq_next;
    logic [SLOT_W-1:0]               pend_slot_reg;
    logic [SLOT_W-1:0]               pend_slot_next;
    swarq_pkg::out_item_t            result_reg;
    swarq_pkg::out_item_t            result_next;
    logic                            result_valid_reg;
    logic                            result_valid_next;

    logic [SLOT_W-1:0]               win;
    logic [RING_W-1:0]               ring;
    logic [swarq_pkg::SEQ_W-1:0]     win_ext;
    logic [swarq_pkg::SEQ_W-1:0]     outstanding;
    logic [swarq_pkg::SEQ_W-1:0]     ack_d;
    logic [swarq_pkg::SEQ_W-1:0]     ack_past;
    logic                            accept;
    logic                            need_mod;
    logic [swarq_pkg::SEQ_W-1:0]     mod_dividend;
    logic                            mod_done;
    logic [SLOT_W-1:0]               mod_rem;
    logic                            sr_in_win;
    logic                            slide_start;
    logic                            slide_go;
    logic                            scan_more;
    logic                            scan_hit;
    logic [SLOT_W-1:0]               slot_step;
    logic                            cfg_clear;
    swarq_pkg::amap_ctrl_t           amap_ctrl;
    logic [SLOT_W-1:0]               amap_rd_addr;
    logic                            amap_rd_bit;

    assign win = (win_cfg_reg == '0) ? SLOT_W'(1) :
                 (win_cfg_reg > MAXW_CFG) ? SLOT_W'(MAX_WINDOW) :
                 win_cfg_reg[SLOT_W-1:0];
    assign ring    = RING_W'(win) + RING_W'(1);
    assign win_ext = swarq_pkg::SEQ_W'(win);

    assign outstanding = next_seq_reg - base_seq_reg;
    assign ack_d       = item_reg.ack_seq - base_seq_reg;
    assign ack_past    = item_reg.ack_seq - next_seq_reg;

    assign accept   = start && (state_reg == swarq_pkg::S_IDLE);
    assign busy     = (state_reg != swarq_pkg::S_IDLE);
    assign need_mod = (item.action == swarq_pkg::ACT_SEND) ||
                      (item.action == swarq_pkg::ACT_TIMEOUT) ||
                      ((item.action == swarq_pkg::ACT_ACK) && item.ack_good && repeat_mode_reg);
    assign mod_dividend = (item.action == swarq_pkg::ACT_SEND) ? next_seq_reg :
                          (item.action == swarq_pkg::ACT_ACK)  ? item.ack_seq : base_seq_reg;

    assign sr_in_win   = repeat_mode_reg && item_reg.ack_good && (ack_d < outstanding);
    assign slide_start = (item_reg.action == swarq_pkg::ACT_ACK) && sr_in_win && (ack_d == '0);
    assign slide_go    = (cnt_reg < win) && amap_rd_bit;
    assign scan_more   = (cnt_reg < lim_reg);
    assign scan_hit    = !(repeat_mode_reg && amap_rd_bit);
    assign slot_step   = ((seq_reg == '1) || (slot_reg == win)) ? '0 : slot_reg + 1'b1;

    assign cfg_clear = cfg_wr_en &&
                       ((cfg_index == swarq_pkg::CFG_WINDOW) || (cfg_index == swarq_pkg::CFG_MODE));

    swarq_mod_unit #(
        .SLOT_W (SLOT_W),
        .RING_W (RING_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && need_mod),
        .dividend (mod_dividend),
        .divisor  (ring),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    swarq_ack_map #(
        .DEPTH (DEPTH),
        .AW    (SLOT_W)
    ) u_amap (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (amap_ctrl),
        .set_addr (mod_rem),
        .clr_addr (slot_reg),
        .rd_addr  (amap_rd_addr),
        .rd_bit   (amap_rd_bit)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swarq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_mod ? swarq_pkg::S_MOD : swarq_pkg::S_EXEC;
                end
            end
            swarq_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = swarq_pkg::S_EXEC;
                end
            end
            swarq_pkg::S_EXEC:
            begin
                if (item_reg.action == swarq_pkg::ACT_TIMEOUT)
                begin
                    state_next = swarq_pkg::S_SCAN;
                end
                else if (slide_start)
                begin
                    state_next = swarq_pkg::S_SLIDE;
                end
                else
                begin
                    state_next = swarq_pkg::S_IDLE;
                end
            end
            swarq_pkg::S_SLIDE:
            begin
                if (!slide_go)
                begin
                    state_next = swarq_pkg::S_IDLE;
                end
            end
            swarq_pkg::S_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = swarq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = swarq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next         = item_reg;
        next_seq_next     = next_seq_reg;
        base_seq_next     = base_seq_reg;
        seq_next          = seq_reg;
        slot_next         = slot_reg;
        cnt_next          = cnt_reg;
        lim_next          = lim_reg;
        pend_valid_next   = pend_valid_reg;
        pend_seq_next     = pend_seq_reg;
        pend_slot_next    = pend_slot_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        amap_ctrl         = '0;
        amap_ctrl.clear_all = cfg_clear;
        amap_rd_addr      = slot_reg;

        case (state_reg)
            swarq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                end
            end
            swarq_pkg::S_MOD:
            begin
            end
            swarq_pkg::S_EXEC:
            begin
                amap_rd_addr = mod_rem;
                result_next.packet_seq  = '0;
                result_next.slot_index  = '0;
                result_next.last_of_run = 1'b1;
                case (item_reg.action)
                    swarq_pkg::ACT_SEND:
                    begin
                        result_valid_next = 1'b1;
                        if ((outstanding < win_ext) && !(repeat_mode_reg && amap_rd_bit))
                        begin
                            next_seq_next          = next_seq_reg + 1'b1;
                            result_next.status     = swarq_pkg::STAT_NEW;
                            result_next.packet_seq = next_seq_reg;
                            result_next.slot_index = swarq_pkg::OUT_SLOT_W'(mod_rem);
                        end
                        else
                        begin
                            result_next.status = swarq_pkg::STAT_FULL;
                        end
                    end
                    swarq_pkg::ACT_ACK:
                    begin
                        result_next.status = swarq_pkg::STAT_ACK;
                        if (item_reg.ack_good && !repeat_mode_reg)
                        begin
                            if (ack_d <= outstanding)
                            begin
                                base_seq_next = item_reg.ack_seq;
                            end
                            else if (!ack_past[swarq_pkg::SEQ_W-1])
                            begin
                                result_next.status = swarq_pkg::STAT_ERROR;
                            end
                        end
                        else if (item_reg.ack_good)
                        begin
                            if (sr_in_win)
                            begin
                                amap_ctrl.set_en = 1'b1;
                            end
                            else if (!ack_past[swarq_pkg::SEQ_W-1])
                            begin
                                result_next.status = swarq_pkg::STAT_ERROR;
                            end
                        end
                        if (slide_start)
                        begin
                            seq_next  = base_seq_reg;
                            slot_next = mod_rem;
                            cnt_next  = '0;
                        end
                        else
                        begin
                            result_valid_next = 1'b1;
                        end
                    end
                    swarq_pkg::ACT_TIMEOUT:
                    begin
                        lim_next        = (outstanding < win_ext) ?
                                          outstanding[SLOT_W-1:0] : win;
                        seq_next        = base_seq_reg;
                        slot_next       = mod_rem;
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                    end
                    default:
                    begin
                        result_valid_next  = 1'b1;
                        result_next.status = swarq_pkg::STAT_ERROR;
                    end
                endcase
            end
            swarq_pkg::S_SLIDE:
            begin
                if (slide_go)
                begin
                    amap_ctrl.clr_en = 1'b1;
                    base_seq_next    = base_seq_reg + 1'b1;
                    seq_next         = seq_reg + 1'b1;
                    slot_next        = slot_step;
                    cnt_next         = cnt_reg + 1'b1;
                end
                else
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = swarq_pkg::STAT_ACK;
                    result_next.packet_seq  = '0;
                    result_next.slot_index  = '0;
                    result_next.last_of_run = 1'b1;
                end
            end
            swarq_pkg::S_SCAN:
            begin
                if (scan_more)
                begin
                    if (scan_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            result_valid_next       = 1'b1;
                            result_next.status      = swarq_pkg::STAT_RESEND;
                            result_next.packet_seq  = pend_seq_reg;
                            result_next.slot_index  = swarq_pkg::OUT_SLOT_W'(pend_slot_reg);
                            result_next.last_of_run = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_seq_next   = seq_reg;
                        pend_slot_next  = slot_reg;
                    end
                    seq_next  = seq_reg + 1'b1;
                    slot_next = slot_step;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    result_valid_next       = 1'b1;
                    result_next.last_of_run = 1'b1;
                    if (pend_valid_reg)
                    begin
                        result_next.status     = swarq_pkg::STAT_RESEND;
                        result_next.packet_seq = pend_seq_reg;
                        result_next.slot_index = swarq_pkg::OUT_SLOT_W'(pend_slot_reg);
                    end
                    else
                    begin
                        result_next.status     = swarq_pkg::STAT_NONE;
                        result_next.packet_seq = '0;
                        result_next.slot_index = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (result_valid_next)
        begin
            result_next.window_base = base_seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swarq_pkg::S_IDLE;
            win_cfg_reg      <= swarq_pkg::WINDOW_RESET;
            repeat_mode_reg  <= 1'b0;
            next_seq_reg     <= '0;
            base_seq_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            next_seq_reg     <= next_seq_next;
            base_seq_reg     <= base_seq_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en && (cfg_index == swarq_pkg::CFG_WINDOW))
            begin
                win_cfg_reg <= cfg_data;
            end
            if (cfg_wr_en && (cfg_index == swarq_pkg::CFG_MODE))
            begin
                repeat_mode_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        seq_reg       <= seq_next;
        slot_reg      <= slot_next;
        cnt_reg       <= cnt_next;
        lim_reg       <= lim_next;
        pend_seq_reg  <= pend_seq_next;
        pend_slot_reg <= pend_slot_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> src/swarq_mod_unit.sv
// Iterative remainder unit: sequence number modulo ring size, four bits per cycle.
module swarq_mod_unit #(
    parameter int SLOT_W = 6,
    parameter int RING_W = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swarq_pkg::SEQ_W-1:0] dividend,
    input  logic [RING_W-1:0]           divisor,
    output logic                        done,
    output logic [SLOT_W-1:0]           rem
);

    logic                           run_reg;
    logic                           run_next;
    logic                           done_reg;
    logic                           done_next;
    logic [swarq_pkg::MOD_CNT_W-1:0] step_reg;
    logic [swarq_pkg::MOD_CNT_W-1:0] step_next;
    logic [swarq_pkg::SEQ_W-1:0]    dvd_reg;
    logic [swarq_pkg::SEQ_W-1:0]    dvd_next;
    logic [SLOT_W-1:0]              rem_reg;
    logic [SLOT_W-1:0]              rem_next;
    logic [SLOT_W-1:0]              rem_step;

    always_comb
    begin
        logic [SLOT_W:0] t;
        logic [SLOT_W:0] d_ext;
        d_ext = (SLOT_W+1)'(divisor);
        rem_step = rem_reg;
        for (int k = 0; k < swarq_pkg::MOD_STEP_BITS; k++)
        begin
            t = {rem_step, dvd_reg[swarq_pkg::SEQ_W-1-k]};
            if (t >= d_ext)
            begin
                t = t - d_ext;
            end
            rem_step = t[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (run_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = dvd_reg << swarq_pkg::MOD_STEP_BITS;
            step_next = step_reg + 1'b1;
            if (step_reg == swarq_pkg::MOD_CNT_W'(swarq_pkg::MOD_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> src/swarq_ack_map.sv
// Per-slot acknowledge flags with clear-all, single set, single clear and one read port.
module swarq_ack_map #(
    parameter int DEPTH = 33,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swarq_pkg::amap_ctrl_t ctrl,
    input  logic [AW-1:0]         set_addr,
    input  logic [AW-1:0]         clr_addr,
    input  logic [AW-1:0]         rd_addr,
    output logic                  rd_bit
);

    logic [DEPTH-1:0] bits_reg;
    logic [DEPTH-1:0] bits_next;

    always_comb
    begin
        bits_next = bits_reg;
        if (ctrl.clear_all)
        begin
            bits_next = '0;
        end
        else
        begin
            if (ctrl.set_en)
            begin
                bits_next[set_addr] = 1'b1;
            end
            if (ctrl.clr_en)
            begin
                bits_next[clr_addr] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    assign rd_bit = bits_reg[rd_addr];

endmodule
